// ----- hw/rtl/mplf_pkg.sv -----
package mplf_pkg;

  localparam int TIMER_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int MAX_BATCH       = 3;

  localparam logic [15:0] RESET_LOCAL_LINK_ID   = 16'd0;
  localparam logic [15:0] RESET_RETRY_TIMEOUT   = 16'd40;
  localparam logic [15:0] RESET_HOLDING_TIMEOUT = 16'd40;
  localparam logic [15:0] RESET_CONFIRM_TIMEOUT = 16'd40;
  localparam logic [15:0] RESET_MAX_RETRIES     = 16'd4;
  localparam logic [7:0]  RESET_MAX_BEACON_LOSS = 8'd2;

  localparam logic [3:0] EV_CNCL   = 4'd0;
  localparam logic [3:0] EV_REQ    = 4'd1;
  localparam logic [3:0] EV_ACTOPN = 4'd2;
  localparam logic [3:0] EV_CLS    = 4'd3;
  localparam logic [3:0] EV_OPNA   = 4'd4;
  localparam logic [3:0] EV_OPNR   = 4'd5;
  localparam logic [3:0] EV_CNFA   = 4'd6;
  localparam logic [3:0] EV_CNFR   = 4'd7;
  localparam logic [3:0] EV_TOR1   = 4'd8;
  localparam logic [3:0] EV_TOR2   = 4'd9;
  localparam logic [3:0] EV_TOC    = 4'd10;
  localparam logic [3:0] EV_TOH    = 4'd11;

  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_TICK   = 2'd1;
  localparam logic [1:0] OP_BEACON = 2'd2;
  localparam logic [1:0] OP_EVENT  = 2'd3;

  localparam logic [1:0] ID_NONE  = 2'd0;
  localparam logic [1:0] ID_LEARN = 2'd1;
  localparam logic [1:0] ID_CLOSE = 2'd2;
  localparam logic [1:0] ID_CONF  = 2'd3;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] sender_link_id;
    logic [15:0] target_link_id;
    logic [7:0]  reason;
    logic [15:0] beacon_interval;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [2:0]  old_state;
    logic [2:0]  new_state;
    logic [15:0] frame_local_id;
    logic [15:0] frame_peer_id;
    logic [7:0]  close_reason;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  ev;
    logic [1:0]  idm;
    logic [15:0] snd;
    logic [15:0] tgt;
    logic [7:0]  rsn;
    logic [15:0] bi;
  } cls_item_t;

  typedef struct packed {
    logic [15:0] local_link_id;
    logic [15:0] retry_timeout;
    logic [15:0] holding_timeout;
    logic [15:0] confirm_timeout;
    logic [15:0] max_retries;
    logic [7:0]  max_beacon_loss;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] old_st;
    logic [2:0] new_st;
    logic [7:0] rsn;
  } res_code_t;

endpackage

// ----- hw/rtl/mplf_fifo.sv -----
module mplf_fifo #(
  parameter int DEPTH = mplf_pkg::QUEUE_DEPTH_DEF,
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_data,
  output logic  full,
  input  logic  pop,
  output item_t pop_data,
  output logic  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  logic [AW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/mplf_front.sv -----
module mplf_front (
  input  logic                 in_valid,
  input  mplf_pkg::in_item_t   in_data,
  output logic                 in_stall,
  input  logic                 q_full,
  output logic                 q_push,
  output mplf_pkg::cls_item_t  q_data
);

  mplf_pkg::cls_item_t cls;

  always_comb begin
    cls     = '0;
    cls.snd = in_data.sender_link_id;
    cls.tgt = in_data.target_link_id;
    cls.rsn = in_data.reason;
    cls.bi  = in_data.beacon_interval;
    unique case (in_data.kind)
      4'd0: cls.op = mplf_pkg::OP_TICK;
      4'd1: cls.op = mplf_pkg::OP_BEACON;
      4'd2: begin
        cls.op = mplf_pkg::OP_EVENT;
        cls.ev = mplf_pkg::EV_ACTOPN;
      end
      4'd3: begin
        cls.op = mplf_pkg::OP_EVENT;
        cls.ev = mplf_pkg::EV_CNCL;
      end
      4'd4: begin
        cls.op = mplf_pkg::OP_EVENT;
        cls.ev = mplf_pkg::EV_REQ;
      end
      4'd5: begin
        cls.op  = mplf_pkg::OP_EVENT;
        cls.ev  = mplf_pkg::EV_CLS;
        cls.idm = mplf_pkg::ID_CLOSE;
      end
      4'd6: begin
        cls.op  = mplf_pkg::OP_EVENT;
        cls.ev  = mplf_pkg::EV_OPNA;
        cls.idm = mplf_pkg::ID_LEARN;
      end
      4'd7: begin
        cls.op  = mplf_pkg::OP_EVENT;
        cls.ev  = mplf_pkg::EV_OPNR;
        cls.idm = mplf_pkg::ID_LEARN;
      end
      4'd8: begin
        cls.op  = mplf_pkg::OP_EVENT;
        cls.ev  = mplf_pkg::EV_CNFA;
        cls.idm = mplf_pkg::ID_CONF;
      end
      4'd9: begin
        cls.op  = mplf_pkg::OP_EVENT;
        cls.ev  = mplf_pkg::EV_CNFR;
        cls.idm = mplf_pkg::ID_CONF;
      end
      default: cls.op = mplf_pkg::OP_NONE;
    endcase
  end

  // Unused kinds are taken and dropped here.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (cls.op != mplf_pkg::OP_NONE);
  assign q_data   = cls;

endmodule

// ----- hw/rtl/mplf_back.sv -----
module mplf_back #(
  parameter int TIMER_WIDTH = mplf_pkg::TIMER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mplf_pkg::cfg_t       cfg,
  input  logic                 q_empty,
  input  mplf_pkg::cls_item_t  q_head,
  output logic                 q_pop,
  input  logic                 o_full,
  output logic                 o_push,
  output mplf_pkg::out_item_t  o_item
);

  localparam int TW = TIMER_WIDTH;
  localparam int EW = (TW > 16) ? TW : 16;

  localparam logic P_IDLE = 1'b0;
  localparam logic P_RUN  = 1'b1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OSNT = 3'd1;
  localparam logic [2:0] ST_CRCV = 3'd2;
  localparam logic [2:0] ST_ORCV = 3'd3;
  localparam logic [2:0] ST_ESTB = 3'd4;
  localparam logic [2:0] ST_HOLD = 3'd5;

  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_OPEN   = 2'd1;
  localparam logic [1:0] RK_CONF   = 2'd2;
  localparam logic [1:0] RK_CLOSE  = 2'd3;

  localparam logic [7:0] RSN_CANCEL      = 8'd0;
  localparam logic [7:0] RSN_CLOSE_RCVD  = 8'd1;
  localparam logic [7:0] RSN_MAX_RETRIES = 8'd2;
  localparam logic [7:0] RSN_CONF_TO     = 8'd3;

  localparam logic [1:0] TA_KEEP = 2'd0;
  localparam logic [1:0] TA_SET  = 2'd1;
  localparam logic [1:0] TA_CLR  = 2'd2;

  typedef struct packed {
    logic [2:0]                                    nstate;
    logic [1:0]                                    cnt;
    mplf_pkg::res_code_t [mplf_pkg::MAX_BATCH-1:0] res;
    logic [1:0]                                    rta;
    logic [1:0]                                    cta;
    logic [1:0]                                    hta;
    logic                                          rinc;
  } mach_t;

  function automatic mplf_pkg::res_code_t st_res(input logic [2:0] o, input logic [2:0] n);
    mplf_pkg::res_code_t c;
    c        = '0;
    c.kind   = RK_STATUS;
    c.old_st = o;
    c.new_st = n;
    return c;
  endfunction

  function automatic mplf_pkg::res_code_t fr_res(input logic [1:0] k, input logic [7:0] r);
    mplf_pkg::res_code_t c;
    c      = '0;
    c.kind = k;
    c.rsn  = r;
    return c;
  endfunction

  function automatic mach_t to_hold(input logic [2:0] s, input logic cr, input logic cc,
                                    input logic [7:0] r);
    mach_t m;
    m        = '0;
    m.nstate = ST_HOLD;
    m.cnt    = 2'd2;
    m.res[0] = st_res(s, ST_HOLD);
    m.res[1] = fr_res(RK_CLOSE, r);
    m.rta    = cr ? TA_CLR : TA_KEEP;
    m.cta    = cc ? TA_CLR : TA_KEEP;
    m.hta    = TA_SET;
    return m;
  endfunction

  function automatic mach_t machine(input logic [2:0] s, input logic [3:0] ev,
                                    input logic [7:0] rsn);
    mach_t m;
    m        = '0;
    m.nstate = s;
    unique case (s)
      ST_IDLE: begin
        if (ev == mplf_pkg::EV_CNCL || ev == mplf_pkg::EV_CLS) begin
          m.cnt    = 2'd1;
          m.res[0] = st_res(ST_IDLE, ST_IDLE);
        end else if (ev == mplf_pkg::EV_REQ) begin
          m.cnt    = 2'd1;
          m.res[0] = fr_res(RK_CLOSE, RSN_CANCEL);
        end else if (ev == mplf_pkg::EV_ACTOPN) begin
          m.nstate = ST_OSNT;
          m.cnt    = 2'd2;
          m.res[0] = st_res(ST_IDLE, ST_OSNT);
          m.res[1] = fr_res(RK_OPEN, 8'd0);
          m.rta    = TA_SET;
        end else if (ev == mplf_pkg::EV_OPNA) begin
          m.nstate = ST_ORCV;
          m.cnt    = 2'd3;
          m.res[0] = st_res(ST_IDLE, ST_ORCV);
          m.res[1] = fr_res(RK_CONF, 8'd0);
          m.res[2] = fr_res(RK_OPEN, 8'd0);
          m.rta    = TA_SET;
        end
      end
      ST_OSNT, ST_ORCV: begin
        if (ev == mplf_pkg::EV_TOR1) begin
          m.cnt    = 2'd1;
          m.res[0] = fr_res(RK_OPEN, 8'd0);
          m.rta    = TA_SET;
          m.rinc   = 1'b1;
        end else if (ev == mplf_pkg::EV_CNFA && s == ST_OSNT) begin
          m.nstate = ST_CRCV;
          m.cnt    = 2'd1;
          m.res[0] = st_res(s, ST_CRCV);
          m.rta    = TA_CLR;
          m.cta    = TA_SET;
        end else if (ev == mplf_pkg::EV_CNFA) begin
          m.nstate = ST_ESTB;
          m.cnt    = 2'd1;
          m.res[0] = st_res(s, ST_ESTB);
          m.rta    = TA_CLR;
        end else if (ev == mplf_pkg::EV_OPNA && s == ST_OSNT) begin
          m.nstate = ST_ORCV;
          m.cnt    = 2'd2;
          m.res[0] = st_res(s, ST_ORCV);
          m.res[1] = fr_res(RK_CONF, 8'd0);
        end else if (ev == mplf_pkg::EV_CLS) begin
          m = to_hold(s, 1'b1, 1'b0, RSN_CLOSE_RCVD);
        end else if (ev == mplf_pkg::EV_OPNR || ev == mplf_pkg::EV_CNFR) begin
          m = to_hold(s, 1'b1, 1'b0, rsn);
        end else if (ev == mplf_pkg::EV_TOR2) begin
          m = to_hold(s, 1'b1, 1'b0, RSN_MAX_RETRIES);
        end else if (ev == mplf_pkg::EV_CNCL) begin
          m = to_hold(s, 1'b1, 1'b0, RSN_CANCEL);
        end
      end
      ST_CRCV: begin
        if (ev == mplf_pkg::EV_OPNA) begin
          m.nstate = ST_ESTB;
          m.cnt    = 2'd2;
          m.res[0] = st_res(s, ST_ESTB);
          m.res[1] = fr_res(RK_CONF, 8'd0);
          m.cta    = TA_CLR;
        end else if (ev == mplf_pkg::EV_CLS) begin
          m = to_hold(s, 1'b0, 1'b1, RSN_CLOSE_RCVD);
        end else if (ev == mplf_pkg::EV_OPNR || ev == mplf_pkg::EV_CNFR) begin
          m = to_hold(s, 1'b0, 1'b1, rsn);
        end else if (ev == mplf_pkg::EV_CNCL) begin
          m = to_hold(s, 1'b0, 1'b1, RSN_CANCEL);
        end else if (ev == mplf_pkg::EV_TOC) begin
          m = to_hold(s, 1'b0, 1'b0, RSN_CONF_TO);
        end
      end
      ST_ESTB: begin
        if (ev == mplf_pkg::EV_OPNA) begin
          m.cnt    = 2'd1;
          m.res[0] = fr_res(RK_CONF, 8'd0);
        end else if (ev == mplf_pkg::EV_CLS) begin
          m = to_hold(s, 1'b0, 1'b0, RSN_CLOSE_RCVD);
        end else if (ev == mplf_pkg::EV_OPNR || ev == mplf_pkg::EV_CNFR) begin
          m = to_hold(s, 1'b1, 1'b0, rsn);
        end else if (ev == mplf_pkg::EV_CNCL) begin
          m = to_hold(s, 1'b0, 1'b0, RSN_CANCEL);
        end
      end
      default: begin
        if (ev == mplf_pkg::EV_CLS) begin
          m.nstate = ST_IDLE;
          m.cnt    = 2'd1;
          m.res[0] = st_res(ST_HOLD, ST_IDLE);
          m.hta    = TA_CLR;
        end else if (ev == mplf_pkg::EV_TOH) begin
          m.nstate = ST_IDLE;
          m.cnt    = 2'd1;
          m.res[0] = st_res(ST_HOLD, ST_IDLE);
        end else if (ev == mplf_pkg::EV_OPNA || ev == mplf_pkg::EV_CNFA) begin
          m.nstate = ST_HOLD;
          m.cnt    = 2'd2;
          m.res[0] = st_res(ST_HOLD, ST_HOLD);
          m.res[1] = fr_res(RK_CLOSE, RSN_CANCEL);
        end else if (ev == mplf_pkg::EV_OPNR || ev == mplf_pkg::EV_CNFR) begin
          m.nstate = ST_HOLD;
          m.cnt    = 2'd2;
          m.res[0] = st_res(ST_HOLD, ST_HOLD);
          m.res[1] = fr_res(RK_CLOSE, rsn);
        end
      end
    endcase
    return m;
  endfunction

  function automatic logic [TW-1:0] load_t(input logic [15:0] t);
    logic [EW-1:0] e;
    logic [EW-1:0] mx;
    e  = EW'(t);
    mx = EW'({TW{1'b1}});
    return (e > mx) ? mx[TW-1:0] : e[TW-1:0];
  endfunction

  function automatic mplf_pkg::out_item_t build(input mplf_pkg::res_code_t c,
                                                input logic last,
                                                input logic [15:0] lid,
                                                input logic [15:0] pid);
    mplf_pkg::out_item_t o;
    o              = '0;
    o.result_kind  = c.kind;
    o.old_state    = c.old_st;
    o.new_state    = c.new_st;
    o.close_reason = c.rsn;
    o.last         = last;
    if (c.kind != RK_STATUS) begin
      o.frame_local_id = lid;
    end
    if (c.kind == RK_CONF || c.kind == RK_CLOSE) begin
      o.frame_peer_id = pid;
    end
    return o;
  endfunction

  logic                phase_r, phase_nxt;
  logic [2:0]          state_r, state_nxt;
  logic [15:0]         peer_r, peer_nxt;
  logic [15:0]         retry_cnt_r, retry_cnt_nxt;
  logic [TW-1:0]       rcd_r, rcd_nxt, ccd_r, ccd_nxt, hcd_r, hcd_nxt;
  logic [23:0]         bcd_r, bcd_nxt;
  logic                pend_hold_r, pend_hold_nxt, pend_conf_r, pend_conf_nxt;
  logic                pend_retry_r, pend_retry_nxt, pend_bl_r, pend_bl_nxt;
  logic [1:0]          bcnt_r, bcnt_nxt, bidx_r, bidx_nxt;
  logic                held_vld_r, held_vld_nxt;
  mplf_pkg::res_code_t [mplf_pkg::MAX_BATCH-1:0] bat_r, bat_nxt;
  mplf_pkg::res_code_t held_r, held_nxt;

  logic                eval_en;
  logic [3:0]          sel_ev;
  logic [7:0]          sel_rsn;
  mach_t               mach;
  logic                chk_tgt, tgt_bad, id_ok;
  logic [15:0]         peer_learn;
  logic                any_pend;

  assign any_pend = pend_hold_r || pend_conf_r || pend_retry_r || pend_bl_r;

  always_comb begin
    chk_tgt = (q_head.idm == mplf_pkg::ID_CLOSE) || (q_head.idm == mplf_pkg::ID_CONF);
    tgt_bad = chk_tgt && ((q_head.idm == mplf_pkg::ID_CONF) || (q_head.tgt != 16'd0))
              && (q_head.tgt != cfg.local_link_id);
    id_ok      = 1'b1;
    peer_learn = peer_r;
    if (q_head.idm != mplf_pkg::ID_NONE) begin
      if (tgt_bad) begin
        id_ok = 1'b0;
      end else if (peer_r == 16'd0) begin
        peer_learn = q_head.snd;
      end else if (chk_tgt && (peer_r != q_head.snd)) begin
        id_ok = 1'b0;
      end
    end
  end

  always_comb begin
    if (phase_r == P_IDLE) begin
      sel_ev  = q_head.ev;
      sel_rsn = q_head.rsn;
    end else begin
      sel_rsn = 8'd0;
      if (pend_hold_r) begin
        sel_ev = mplf_pkg::EV_TOH;
      end else if (pend_conf_r) begin
        sel_ev = mplf_pkg::EV_TOC;
      end else if (pend_retry_r) begin
        sel_ev = (retry_cnt_r < cfg.max_retries) ? mplf_pkg::EV_TOR1 : mplf_pkg::EV_TOR2;
      end else begin
        sel_ev = mplf_pkg::EV_CNCL;
      end
    end
  end

  assign mach = machine(state_r, sel_ev, sel_rsn);

  always_comb begin
    phase_nxt      = phase_r;
    state_nxt      = state_r;
    peer_nxt       = peer_r;
    retry_cnt_nxt  = retry_cnt_r;
    rcd_nxt        = rcd_r;
    ccd_nxt        = ccd_r;
    hcd_nxt        = hcd_r;
    bcd_nxt        = bcd_r;
    pend_hold_nxt  = pend_hold_r;
    pend_conf_nxt  = pend_conf_r;
    pend_retry_nxt = pend_retry_r;
    pend_bl_nxt    = pend_bl_r;
    bcnt_nxt       = bcnt_r;
    bidx_nxt       = bidx_r;
    bat_nxt        = bat_r;
    held_vld_nxt   = held_vld_r;
    held_nxt       = held_r;
    q_pop          = 1'b0;
    o_push         = 1'b0;
    o_item         = build(held_r, 1'b0, cfg.local_link_id, peer_r);
    eval_en        = 1'b0;

    if (phase_r == P_IDLE) begin
      if (!q_empty) begin
        q_pop = 1'b1;
        unique case (q_head.op)
          mplf_pkg::OP_TICK: begin
            hcd_nxt        = hcd_r - TW'(hcd_r != '0);
            ccd_nxt        = ccd_r - TW'(ccd_r != '0);
            rcd_nxt        = rcd_r - TW'(rcd_r != '0);
            bcd_nxt        = bcd_r - 24'(bcd_r != '0);
            pend_hold_nxt  = (hcd_r == TW'(1));
            pend_conf_nxt  = (ccd_r == TW'(1));
            pend_retry_nxt = (rcd_r == TW'(1));
            pend_bl_nxt    = (bcd_r == 24'd1);
            phase_nxt      = P_RUN;
          end
          mplf_pkg::OP_BEACON: begin
            bcd_nxt = {8'd0, q_head.bi} * {16'd0, cfg.max_beacon_loss};
          end
          mplf_pkg::OP_EVENT: begin
            if (id_ok) begin
              peer_nxt  = peer_learn;
              eval_en   = 1'b1;
              phase_nxt = P_RUN;
            end else begin
              peer_nxt = peer_learn;
            end
          end
          default: ;
        endcase
      end
    end else begin
      if (bcnt_r != 2'd0) begin
        if (!held_vld_r || !o_full) begin
          o_push       = held_vld_r;
          held_nxt     = bat_r[bidx_r];
          held_vld_nxt = 1'b1;
          bidx_nxt     = bidx_r + 2'd1;
          bcnt_nxt     = bcnt_r - 2'd1;
        end
      end else if (any_pend) begin
        eval_en = 1'b1;
        if (pend_hold_r) begin
          pend_hold_nxt = 1'b0;
        end else if (pend_conf_r) begin
          pend_conf_nxt = 1'b0;
        end else if (pend_retry_r) begin
          pend_retry_nxt = 1'b0;
        end else begin
          pend_bl_nxt = 1'b0;
        end
      end else if (held_vld_r) begin
        // The held beat is the final one of this item.
        if (!o_full) begin
          o_push       = 1'b1;
          o_item       = build(held_r, 1'b1, cfg.local_link_id, peer_r);
          held_vld_nxt = 1'b0;
          phase_nxt    = P_IDLE;
        end
      end else begin
        phase_nxt = P_IDLE;
      end
    end

    if (eval_en) begin
      state_nxt = mach.nstate;
      bat_nxt   = mach.res;
      bcnt_nxt  = mach.cnt;
      bidx_nxt  = 2'd0;
      if (mach.rinc && (retry_cnt_r != 16'hFFFF)) begin
        retry_cnt_nxt = retry_cnt_r + 16'd1;
      end
      case (mach.rta)
        TA_SET: begin
          rcd_nxt        = load_t(cfg.retry_timeout);
          pend_retry_nxt = 1'b0;
        end
        TA_CLR: begin
          rcd_nxt        = '0;
          pend_retry_nxt = 1'b0;
        end
        default: ;
      endcase
      case (mach.cta)
        TA_SET: begin
          ccd_nxt       = load_t(cfg.confirm_timeout);
          pend_conf_nxt = 1'b0;
        end
        TA_CLR: begin
          ccd_nxt       = '0;
          pend_conf_nxt = 1'b0;
        end
        default: ;
      endcase
      case (mach.hta)
        TA_SET: begin
          hcd_nxt       = load_t(cfg.holding_timeout);
          pend_hold_nxt = 1'b0;
        end
        TA_CLR: begin
          hcd_nxt       = '0;
          pend_hold_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= P_IDLE;
      state_r      <= ST_IDLE;
      peer_r       <= '0;
      retry_cnt_r  <= '0;
      rcd_r        <= '0;
      ccd_r        <= '0;
      hcd_r        <= '0;
      bcd_r        <= '0;
      pend_hold_r  <= 1'b0;
      pend_conf_r  <= 1'b0;
      pend_retry_r <= 1'b0;
      pend_bl_r    <= 1'b0;
      bcnt_r       <= '0;
      bidx_r       <= '0;
      held_vld_r   <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      state_r      <= state_nxt;
      peer_r       <= peer_nxt;
      retry_cnt_r  <= retry_cnt_nxt;
      rcd_r        <= rcd_nxt;
      ccd_r        <= ccd_nxt;
      hcd_r        <= hcd_nxt;
      bcd_r        <= bcd_nxt;
      pend_hold_r  <= pend_hold_nxt;
      pend_conf_r  <= pend_conf_nxt;
      pend_retry_r <= pend_retry_nxt;
      pend_bl_r    <= pend_bl_nxt;
      bcnt_r       <= bcnt_nxt;
      bidx_r       <= bidx_nxt;
      held_vld_r   <= held_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bat_r  <= bat_nxt;
    held_r <= held_nxt;
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> !o_full)
    else $error("result beat pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && (phase_r == P_IDLE))
    else $error("event queue popped while empty or busy");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_IDLE) |-> (bcnt_r == 2'd0) && !held_vld_r && !any_pend)
    else $error("idle with results or expiries outstanding");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (o_push && o_item.last) |=> (phase_r == P_IDLE) && !held_vld_r)
    else $error("final beat pushed without ending the item");

endmodule

// ----- hw/rtl/mesh_peer_link_fsm_unit.sv -----
// Mesh peer-link state machine.
// Input channel (in_valid, in_stall, in_data): one event per beat, taken
// whenever the two-entry event queue has room, so a new beat can follow in
// the next cycle while earlier ones are still being handled.
// Output channel (out_valid, out_stall, out_data): status changes and frame
// requests, the final beat of each event marked by last, from a two-entry
// result queue.
// Configuration (cfg_wr_en, cfg_index, cfg_wdata) is to be written while
// idle; the block itself does not enforce this. With the engine free, the
// first result of an event passes the event queue, the engine's batch and
// held beat, and the result queue before it is offered. The engine, which
// sets the rate, takes a beat only when idle; it is done with a beacon or
// a frame dropped on its link ids as it takes it, evaluates any other beat
// and sends its results one by one, then each timer expired on a tick.
// Reset clears the link to idle, all timers to stopped and both queues.
// A stall on the output holds the result queue; the engine waits when it
// is full and the event queue then fills and stalls the input.
module mesh_peer_link_fsm_unit #(
  parameter int TIMER_WIDTH = mplf_pkg::TIMER_WIDTH_DEF,
  parameter int QUEUE_DEPTH = mplf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mplf_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mplf_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_wdata
);

  localparam logic [2:0] REG_LOCAL_LINK_ID   = 3'd0;
  localparam logic [2:0] REG_RETRY_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_HOLDING_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_CONFIRM_TIMEOUT = 3'd3;
  localparam logic [2:0] REG_MAX_RETRIES     = 3'd4;
  localparam logic [2:0] REG_MAX_BEACON_LOSS = 3'd5;

  mplf_pkg::cfg_t       cfg_r, cfg_nxt;
  mplf_pkg::cls_item_t  fq_in, fq_head;
  mplf_pkg::out_item_t  oq_in;
  logic                 fq_push, fq_full, fq_pop, fq_empty;
  logic                 oq_push, oq_full, oq_pop, oq_empty;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LOCAL_LINK_ID:   cfg_nxt.local_link_id   = cfg_wdata;
        REG_RETRY_TIMEOUT:   cfg_nxt.retry_timeout   = cfg_wdata;
        REG_HOLDING_TIMEOUT: cfg_nxt.holding_timeout = cfg_wdata;
        REG_CONFIRM_TIMEOUT: cfg_nxt.confirm_timeout = cfg_wdata;
        REG_MAX_RETRIES:     cfg_nxt.max_retries     = cfg_wdata;
        REG_MAX_BEACON_LOSS: cfg_nxt.max_beacon_loss = cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_link_id   <= mplf_pkg::RESET_LOCAL_LINK_ID;
      cfg_r.retry_timeout   <= mplf_pkg::RESET_RETRY_TIMEOUT;
      cfg_r.holding_timeout <= mplf_pkg::RESET_HOLDING_TIMEOUT;
      cfg_r.confirm_timeout <= mplf_pkg::RESET_CONFIRM_TIMEOUT;
      cfg_r.max_retries     <= mplf_pkg::RESET_MAX_RETRIES;
      cfg_r.max_beacon_loss <= mplf_pkg::RESET_MAX_BEACON_LOSS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mplf_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .q_full   (fq_full),
    .q_push   (fq_push),
    .q_data   (fq_in)
  );

  mplf_fifo #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (mplf_pkg::cls_item_t)
  ) u_event_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_in),
    .full      (fq_full),
    .pop       (fq_pop),
    .pop_data  (fq_head),
    .empty     (fq_empty)
  );

  mplf_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (fq_empty),
    .q_head  (fq_head),
    .q_pop   (fq_pop),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_item  (oq_in)
  );

  mplf_fifo #(
    .DEPTH  (QUEUE_DEPTH),
    .item_t (mplf_pkg::out_item_t)
  ) u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_in),
    .full      (oq_full),
    .pop       (oq_pop),
    .pop_data  (out_data),
    .empty     (oq_empty)
  );

  assign out_valid = !oq_empty;
  assign oq_pop    = out_valid && !out_stall;

endmodule
